// ===== sv/shd_pkg.sv =====
`timescale 1ns / 1ps

package shd_pkg;

  localparam int unsigned AdcW   = 12;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DelayW = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ANALOG_MODE     = 3'd0,
    REG_LOWER_THRESHOLD = 3'd1,
    REG_UPPER_THRESHOLD = 3'd2,
    REG_INVERT_WORK     = 3'd3,
    REG_DEBOUNCE_MS     = 3'd4
  } cfg_reg_e;

  localparam logic [AdcW-1:0]   LowerThrRst   = 12'd1638;
  localparam logic [AdcW-1:0]   UpperThrRst   = 12'd2457;
  localparam logic [DelayW-1:0] DebounceMsRst = 16'd50;

  // status of one debounced switch, as seen by the top level
  typedef struct packed {
    logic stable;       // debounced level before this transaction
    logic stable_next;  // debounced level after this transaction
    logic changed;      // level is taken in this transaction
  } shd_status_t;

endpackage

// ===== sv/shd_settle.sv =====
`timescale 1ns / 1ps

module shd_settle import shd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              raw_i,
  input  logic [TimeW-1:0]  now_i,
  input  logic [DelayW-1:0] delay_i,
  output shd_status_t       status_o
);

  logic             seen_q, seen_d;
  logic             stable_q, stable_d;
  logic [TimeW-1:0] since_q, since_d;
  logic [TimeW-1:0] elapsed;
  logic             raw_moved;
  logic             ripe;

  assign raw_moved = (raw_i != seen_q);
  // wraps modulo 2^32, so a clock that runs backward reads as a long wait
  assign elapsed   = now_i - since_q;
  assign ripe      = !raw_moved && (seen_q != stable_q) &&
                     (elapsed >= {{(TimeW-DelayW){1'b0}}, delay_i});

  always_comb begin
    seen_d   = seen_q;
    stable_d = stable_q;
    since_d  = since_q;
    if (en_i) begin
      if (raw_moved) begin
        seen_d  = raw_i;
        since_d = now_i;
      end else if (ripe) begin
        stable_d = seen_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= 1'b0;
      stable_q <= 1'b0;
      since_q  <= '0;
    end else begin
      seen_q   <= seen_d;
      stable_q <= stable_d;
      since_q  <= since_d;
    end
  end

  assign status_o.stable      = stable_q;
  assign status_o.stable_next = ripe ? seen_q : stable_q;
  assign status_o.changed     = ripe;

endmodule

// ===== sv/switch_hysteresis_debounce_top.sv =====
`timescale 1ns / 1ps
// An input transaction passes the input register, then the result register,
// which holds it while the result side stalls. Throughput: one transaction
// per cycle unless the result side stalls; switch timers update as it advances.
// Reset (async, active low) clears both switch timers and states, empties the
// pipeline and loads the configuration registers with their power-on values.

module switch_hysteresis_debounce_top import shd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [TimeW-1:0]   now_ms_i,
  input  logic [AdcW-1:0]    work_analog_i,
  input  logic               work_pin_i,
  input  logic               steer_pin_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               work_state_o,
  output logic               work_changed_o,
  output logic               steer_state_o,
  output logic               steer_changed_o
);

  // configuration
  logic              analog_mode_q;
  logic [AdcW-1:0]   lower_thr_q;
  logic [AdcW-1:0]   upper_thr_q;
  logic              invert_work_q;
  logic [DelayW-1:0] debounce_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      analog_mode_q <= 1'b0;
      lower_thr_q   <= LowerThrRst;
      upper_thr_q   <= UpperThrRst;
      invert_work_q <= 1'b0;
      debounce_ms_q <= DebounceMsRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ANALOG_MODE:     analog_mode_q <= cfg_wdata_i[0];
        REG_LOWER_THRESHOLD: lower_thr_q   <= cfg_wdata_i[AdcW-1:0];
        REG_UPPER_THRESHOLD: upper_thr_q   <= cfg_wdata_i[AdcW-1:0];
        REG_INVERT_WORK:     invert_work_q <= cfg_wdata_i[0];
        REG_DEBOUNCE_MS:     debounce_ms_q <= cfg_wdata_i[DelayW-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic             s1_valid_q, s1_valid_d;
  logic [TimeW-1:0] s1_now_q;
  logic [AdcW-1:0]  s1_analog_q;
  logic             s1_wpin_q;
  logic             s1_spin_q;
  logic             out_valid_q, out_valid_d;
  logic             in_accept;
  logic             advance;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_accept || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_now_q    <= now_ms_i;
      s1_analog_q <= work_analog_i;
      s1_wpin_q   <= work_pin_i;
      s1_spin_q   <= steer_pin_i;
    end
  end

  // raw levels
  shd_status_t work_st, steer_st;
  logic        work_raw;

  always_comb begin
    if (analog_mode_q) begin
      // lower test wins when the thresholds are crossed
      if (s1_analog_q < lower_thr_q) begin
        work_raw = !invert_work_q;
      end else if (s1_analog_q > upper_thr_q) begin
        work_raw = invert_work_q;
      end else begin
        work_raw = work_st.stable;  // hold band
      end
    end else begin
      work_raw = !s1_wpin_q;
    end
  end

  shd_settle u_work (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .raw_i    (work_raw),
    .now_i    (s1_now_q),
    .delay_i  (debounce_ms_q),
    .status_o (work_st)
  );

  shd_settle u_steer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .raw_i    (!s1_spin_q),
    .now_i    (s1_now_q),
    .delay_i  (debounce_ms_q),
    .status_o (steer_st)
  );

  // result register
  logic work_state_q, work_changed_q, steer_state_q, steer_changed_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      work_state_q    <= work_st.stable_next;
      work_changed_q  <= work_st.changed;
      steer_state_q   <= steer_st.stable_next;
      steer_changed_q <= steer_st.changed;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign work_state_o    = work_state_q;
  assign work_changed_o  = work_changed_q;
  assign steer_state_o   = steer_state_q;
  assign steer_changed_o = steer_changed_q;

endmodule

// ===== sv/shd_checker.sv =====
`timescale 1ns / 1ps

module shd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic work_state_o,
  input logic work_changed_o,
  input logic steer_state_o,
  input logic steer_changed_o
);

  logic out_accept;
  logic last_work_q, last_steer_q;

  assign out_accept = out_valid_o && !out_stall_i;

  // debounced levels of the last delivered transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_work_q  <= 1'b0;
      last_steer_q <= 1'b0;
    end else if (out_accept) begin
      last_work_q  <= work_state_o;
      last_steer_q <= steer_state_o;
    end
  end

  a_work_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_accept |-> (work_changed_o == (work_state_o != last_work_q)))
    else $error("work state moved without change pulse or vice versa");

  a_steer_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_accept |-> (steer_changed_o == (steer_state_o != last_steer_q)))
    else $error("steer state moved without change pulse or vice versa");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(work_state_o) &&
      $stable(work_changed_o) && $stable(steer_state_o) && $stable(steer_changed_o))
    else $error("stalled result dropped or changed");

endmodule

bind switch_hysteresis_debounce_top shd_checker u_shd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .work_state_o    (work_state_o),
  .work_changed_o  (work_changed_o),
  .steer_state_o   (steer_state_o),
  .steer_changed_o (steer_changed_o)
);

// ===== tb/sv/switch_hysteresis_debounce_top_test.sv =====
`timescale 1ns / 1ps

module switch_hysteresis_debounce_top_test;
  import shd_pkg::*;

  localparam int unsigned IdleLimit      = 2000;
  localparam int unsigned LongHoldCycles = 300;
  // indexes past the register map; writes to them must be dropped
  localparam logic [CfgIdxW-1:0] RegUnusedLo = 3'd5;
  localparam logic [CfgIdxW-1:0] RegUnusedHi = 3'd7;

  typedef struct packed {
    logic work_state;
    logic work_changed;
    logic steer_state;
    logic steer_changed;
  } switch_flags_t;

  typedef struct packed {
    logic             seen;
    logic             stable;
    logic [TimeW-1:0] since;
  } switch_timer_t;

  class debounce_checker;
    logic              analog_mode;
    logic [AdcW-1:0]   lower_thr;
    logic [AdcW-1:0]   upper_thr;
    logic              invert_work;
    logic [DelayW-1:0] delay_ms;
    switch_timer_t     work;
    switch_timer_t     steer;
    switch_flags_t     expected_q[$];
    int                errors;

    function new();
      analog_mode = 1'b0;
      lower_thr   = LowerThrRst;
      upper_thr   = UpperThrRst;
      invert_work = 1'b0;
      delay_ms    = DebounceMsRst;
      work        = '0;
      steer       = '0;
      errors      = 0;
    endfunction

    function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
      case (idx)
        REG_ANALOG_MODE:     analog_mode = data[0];
        REG_LOWER_THRESHOLD: lower_thr   = data[AdcW-1:0];
        REG_UPPER_THRESHOLD: upper_thr   = data[AdcW-1:0];
        REG_INVERT_WORK:     invert_work = data[0];
        REG_DEBOUNCE_MS:     delay_ms    = data[DelayW-1:0];
        default: ;
      endcase
    endfunction

    // a new raw level restarts the timer; a held level is taken once the
    // wrapped elapsed time reaches the delay
    function switch_timer_t settle(input switch_timer_t t, input logic raw,
                                   input logic [TimeW-1:0] now, output logic taken);
      logic [TimeW-1:0] elapsed;
      elapsed = now - t.since;
      taken   = 1'b0;
      if (raw != t.seen) begin
        t.seen  = raw;
        t.since = now;
      end else if (t.seen != t.stable && elapsed >= TimeW'(delay_ms)) begin
        t.stable = t.seen;
        taken    = 1'b1;
      end
      return t;
    endfunction

    function void predict_sample(input logic [TimeW-1:0] now, input logic [AdcW-1:0] adc,
                                 input logic wpin, input logic spin);
      logic          work_raw;
      switch_flags_t exp;
      if (analog_mode) begin
        // lower test first, so crossed thresholds resolve to the low side
        if (adc < lower_thr) work_raw = ~invert_work;
        else if (adc > upper_thr) work_raw = invert_work;
        else work_raw = work.stable;
      end else begin
        work_raw = ~wpin;
      end
      work  = settle(work, work_raw, now, exp.work_changed);
      steer = settle(steer, ~spin, now, exp.steer_changed);
      exp.work_state  = work.stable;
      exp.steer_state = steer.stable;
      expected_q.push_back(exp);
    endfunction

    function void check_result(input switch_flags_t got);
      switch_flags_t exp;
      if (expected_q.size() == 0) begin
        $error("result transaction with no sample pending: %b", got);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.work_state !== exp.work_state) begin
        $error("work_state: expected %0b, got %0b", exp.work_state, got.work_state);
        errors++;
      end
      if (got.work_changed !== exp.work_changed) begin
        $error("work_changed: expected %0b, got %0b", exp.work_changed, got.work_changed);
        errors++;
      end
      if (got.steer_state !== exp.steer_state) begin
        $error("steer_state: expected %0b, got %0b", exp.steer_state, got.steer_state);
        errors++;
      end
      if (got.steer_changed !== exp.steer_changed) begin
        $error("steer_changed: expected %0b, got %0b", exp.steer_changed, got.steer_changed);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0]    cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [TimeW-1:0]   now_ms_i;
  logic [AdcW-1:0]    work_analog_i;
  logic               work_pin_i;
  logic               steer_pin_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               work_state_o;
  logic               work_changed_o;
  logic               steer_state_o;
  logic               steer_changed_o;

  debounce_checker sb;
  bit idle_on;
  bit quiet;
  bit hold_req;

  switch_hysteresis_debounce_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .now_ms_i       (now_ms_i),
    .work_analog_i  (work_analog_i),
    .work_pin_i     (work_pin_i),
    .steer_pin_i    (steer_pin_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .work_state_o   (work_state_o),
    .work_changed_o (work_changed_o),
    .steer_state_o  (steer_state_o),
    .steer_changed_o(steer_changed_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic send_sample(input logic [TimeW-1:0] now, input logic [AdcW-1:0] adc,
                             input logic wp, input logic sp, input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    now_ms_i      <= now;
    work_analog_i <= adc;
    work_pin_i    <= wp;
    steer_pin_i   <= sp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.predict_sample(now, adc, wp, sp);
  endtask

  // drain the pipeline so registers can be written safely
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input logic [CfgW-1:0] mode, input logic [CfgW-1:0] lo,
                           input logic [CfgW-1:0] hi, input logic [CfgW-1:0] inv,
                           input logic [CfgW-1:0] db);
    quiesce();
    cfg_write(REG_ANALOG_MODE, mode);
    cfg_write(REG_LOWER_THRESHOLD, lo);
    cfg_write(REG_UPPER_THRESHOLD, hi);
    cfg_write(REG_INVERT_WORK, inv);
    cfg_write(REG_DEBOUNCE_MS, db);
    cfg_we_i <= 1'b0;
  endtask

  // analog sample aimed at one side of the window, with some band and noise
  function automatic logic [AdcW-1:0] pick_analog(input bit low_side);
    int unsigned lo;
    int unsigned hi;
    int unsigned r;
    lo = 32'(sb.lower_thr);
    hi = 32'(sb.upper_thr);
    r  = $urandom_range(0, 15);
    if (r == 0) return AdcW'($urandom);
    if (r == 1) return AdcW'(lo);
    if (r == 2) return AdcW'(hi);
    if (r <= 4) return AdcW'($urandom_range(lo, hi));
    if (low_side) return (lo > 0) ? AdcW'($urandom_range(0, lo - 1)) : '0;
    return (hi < 4095) ? AdcW'($urandom_range(hi + 1, 4095)) : '1;
  endfunction

  function automatic int unsigned pick_gap();
    if (quiet || !idle_on) return 0;
    if ($urandom_range(0, 5) == 0) return $urandom_range(1, 10);
    return 0;
  endfunction

  // switches toggle after random runs of samples, with one-sample bounces and
  // occasional clock jumps
  task automatic run_phase(input int n, input logic [TimeW-1:0] start_ms,
                           input int unsigned step_max);
    logic [TimeW-1:0] t;
    bit               wlvl;
    bit               slvl;
    int unsigned      wrun;
    int unsigned      srun;
    logic             wp;
    logic             sp;
    t    = start_ms;
    wlvl = 1'($urandom);
    slvl = 1'($urandom);
    wrun = $urandom_range(1, 20);
    srun = $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 39))
        0:       t = $urandom;
        1:       t = t - $urandom_range(1, 1000);
        default: t = t + $urandom_range(0, step_max);
      endcase
      wrun = wrun - 1;
      if (wrun == 0) begin
        wlvl = ~wlvl;
        wrun = $urandom_range(1, 20);
      end
      srun = srun - 1;
      if (srun == 0) begin
        slvl = ~slvl;
        srun = $urandom_range(1, 20);
      end
      wp = ~wlvl;
      sp = ~slvl;
      if ($urandom_range(0, 15) == 0) wp = ~wp;
      if ($urandom_range(0, 15) == 0) sp = ~sp;
      send_sample(t, pick_analog(wlvl ^ sb.invert_work), wp, sp, pick_gap());
    end
  endtask

  initial begin : result_side
    int unsigned   long_hold;
    int unsigned   burst;
    logic          stall_next;
    switch_flags_t got;
    long_hold = 0;
    burst     = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.work_state    = work_state_o;
        got.work_changed  = work_changed_o;
        got.steer_state   = steer_state_o;
        got.steer_changed = steer_changed_o;
        sb.check_result(got);
      end
      if (hold_req) begin
        long_hold = LongHoldCycles;
        hold_req  = 1'b0;
      end
      if (long_hold > 0) begin
        long_hold--;
        stall_next = 1'b1;
      end else if (burst > 0) begin
        burst--;
        stall_next = 1'b1;
      end else if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
        burst      = $urandom_range(0, 9);
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall_i <= stall_next;
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin : stimulus
    sb       = new();
    idle_on  = 1'b1;
    quiet    = 1'b0;
    hold_req = 1'b0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= REG_ANALOG_MODE;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    now_ms_i      <= '0;
    work_analog_i <= '0;
    work_pin_i    <= 1'b1;
    steer_pin_i   <= 1'b1;
    out_stall_i   <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // power-on settings: digital pins, 50 ms
    send_sample(32'd0, 12'd0, 1'b1, 1'b1, 0);
    send_sample(32'd10, 12'd4095, 1'b0, 1'b1, 0);
    send_sample(32'd59, 12'd0, 1'b0, 1'b1, 0);
    send_sample(32'd60, 12'd4095, 1'b0, 1'b0, 0);
    send_sample(32'd110, 12'd0, 1'b0, 1'b0, 0);
    // release across the time wrap
    send_sample(32'hFFFF_FFF0, 12'd0, 1'b1, 1'b1, 0);
    send_sample(32'h0000_0021, 12'd0, 1'b1, 1'b1, 0);
    send_sample(32'h0000_0022, 12'd0, 1'b1, 1'b1, 0);
    // clock running backward reads as a long wait
    send_sample(32'd5, 12'd0, 1'b0, 1'b1, 0);
    send_sample(32'd4, 12'd0, 1'b0, 1'b1, 0);

    // zero delay still needs one more sample at the new level; wide data gets masked
    configure(16'hFFFE, 16'hF100, 16'h0E00, 16'h0002, 16'h0000);
    send_sample(32'd100, 12'd0, 1'b1, 1'b0, 0);
    send_sample(32'd100, 12'd0, 1'b1, 1'b0, 0);

    // analog window 256..3584; unused indexes must not disturb anything
    configure(16'hFFFF, 16'hF100, 16'h0E00, 16'h0000, 16'h0000);
    cfg_write(RegUnusedLo, 16'h0000);
    cfg_write(RegUnusedHi, 16'hFFFF);
    cfg_we_i <= 1'b0;
    send_sample(32'd200, 12'd255, 1'b1, 1'b1, 0);
    send_sample(32'd201, 12'd255, 1'b0, 1'b1, 0);
    send_sample(32'd202, 12'd256, 1'b1, 1'b1, 0);
    send_sample(32'd203, 12'd3584, 1'b0, 1'b1, 0);
    send_sample(32'd204, 12'd3585, 1'b1, 1'b1, 0);
    send_sample(32'd205, 12'd4095, 1'b1, 1'b1, 0);

    // crossed thresholds, inverted sense
    configure(16'd1, 16'd3000, 16'd1000, 16'd1, 16'd0);
    send_sample(32'd300, 12'd3500, 1'b1, 1'b1, 0);
    send_sample(32'd301, 12'd3500, 1'b1, 1'b1, 0);
    send_sample(32'd302, 12'd2000, 1'b1, 1'b1, 0);
    send_sample(32'd303, 12'd2000, 1'b1, 1'b1, 0);

    configure(16'd0, 16'd1638, 16'd2457, 16'd0, 16'd50);
    run_phase(200, $urandom, 20);

    configure(16'd1, 16'd1638, 16'd2457, 16'd0, 16'd20);
    run_phase(250, $urandom, 8);

    idle_on = 1'b0;
    configure(16'd1, 16'd0, 16'd4095, 16'd1, 16'd3);
    run_phase(100, $urandom, 2);

    idle_on = 1'b1;
    configure(16'd1, 16'd3000, 16'd1000, 16'd1, 16'd0);
    run_phase(200, $urandom, 3);

    configure(16'd1, 16'd4095, 16'd0, 16'd0, 16'd1);
    run_phase(150, $urandom, 2);

    configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd65535);
    run_phase(200, 32'hFFFF_0000, 9000);

    // receiver holds off while samples keep coming, so the input backs up
    idle_on = 1'b0;
    configure(16'd1, 16'd1000, 16'd3000, 16'd0, 16'd10);
    hold_req = 1'b1;
    run_phase(250, $urandom, 5);

    idle_on = 1'b1;
    quiet   = 1'b1;
    configure(16'd0, 16'd2048, 16'd2048, 16'd1, 16'd5);
    run_phase(200, $urandom, 3);

    quiesce();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/shd_pkg.sv
sv/shd_settle.sv
sv/switch_hysteresis_debounce_top.sv
sv/shd_checker.sv
tb/sv/switch_hysteresis_debounce_top_test.sv
